>>> hdl/type4_tag_ndef_read_sequencer_defines.svh
// assertion helpers for the type 4 tag read sequencer
`ifndef TYPE4_TAG_NDEF_READ_SEQUENCER_DEFINES_SVH
`define TYPE4_TAG_NDEF_READ_SEQUENCER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define T4T_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define T4T_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/t4t_pkg.sv
package t4t_pkg;

    // input opcodes
    localparam logic [1:0] OP_START_READ     = 2'd0;
    localparam logic [1:0] OP_START_PRESENCE = 2'd1;
    localparam logic [1:0] OP_RESP_BYTE      = 2'd2;
    localparam logic [1:0] OP_XFER_FAIL      = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SW   = 2'd1;
    localparam logic [1:0] ST_NO_TLV   = 2'd2;
    localparam logic [1:0] ST_LINK_ERR = 2'd3;

    localparam int HeaderBytes = 1;
    localparam int MaxResults  = 13;
    localparam int ResCntW     = 4;

    localparam logic [7:0]  INS_SELECT = 8'hA4;
    localparam logic [7:0]  INS_READ   = 8'hB0;
    localparam logic [15:0] SW_OK      = 16'h9000;
    localparam logic [15:0] SW_NOT_FND = 16'h6A82;
    localparam logic [7:0]  TLV_NDEF   = 8'h04;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_SEL_V2    = 4'd1,
        PH_SEL_V1    = 4'd2,
        PH_SEL_CC    = 4'd3,
        PH_READ_CC   = 4'd4,
        PH_SEL_NDEF  = 4'd5,
        PH_READ_NLEN = 4'd6,
        PH_READ_DATA = 4'd7,
        PH_PRESENCE  = 4'd8
    } phase_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        item_last;
        logic [1:0]  status;
        logic [15:0] ndef_length;
        logic        read_only;
        logic [15:0] ndef_file_max;
        logic [15:0] max_command_data;
    } result_t;

    // burst request from sequencer core to emitter
    typedef enum logic [2:0] {
        BR_NONE   = 3'd0,
        BR_SEL_V2 = 3'd1,
        BR_SEL_V1 = 3'd2,
        BR_SEL_FI = 3'd3,
        BR_READ   = 3'd4,
        BR_DONE   = 3'd5
    } burst_t;

    typedef struct packed {
        burst_t      burst;
        logic        data_vld;
        logic [7:0]  data_byte;
        logic [15:0] fid;
        logic [15:0] offset;
        logic [7:0]  le;
        logic [1:0]  status;
        logic [15:0] ndef_length;
        logic        read_only;
        logic [15:0] ndef_file_max;
        logic [15:0] max_command_data;
    } burst_req_t;

endpackage

>>> hdl/t4t_core.sv
module t4t_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_vld,
    input  logic [1:0]           in_op,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output t4t_pkg::burst_req_t  req
);

    t4t_pkg::phase_t phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] swd_reg, swd_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] nlen_reg, nlen_next;
    logic [15:0] mle_reg, mle_next;
    logic [15:0] mlc_reg, mlc_next;
    logic [15:0] mnd_reg, mnd_next;
    logic [7:0]  wacc_reg, wacc_next;
    logic [15:0] fid_reg, fid_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  fsb_reg, fsb_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= t4t_pkg::PH_IDLE;
            cnt_reg <= '0; swd_reg <= '0; off_reg <= '0; nlen_reg <= '0;
            mle_reg <= '0; mlc_reg <= '0; mnd_reg <= '0; wacc_reg <= '0;
            fid_reg <= '0; tag_reg <= '0; fsb_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next; swd_reg <= swd_next; off_reg <= off_next;
            nlen_reg <= nlen_next; mle_reg <= mle_next; mlc_reg <= mlc_next;
            mnd_reg <= mnd_next; wacc_reg <= wacc_next; fid_reg <= fid_next;
            tag_reg <= tag_next; fsb_reg <= fsb_next;
        end
    end

    logic [15:0] pos;
    logic [15:0] p;
    logic [7:0]  rb;
    logic [15:0] sw;
    logic [15:0] n;
    logic [16:0] off_sum;
    logic [15:0] mle_sub;
    logic [15:0] new_off;
    logic [15:0] rem;
    logic [15:0] le_w;
    logic [16:0] data_pos;

    always_comb begin
        phase_next = phase_reg;
        cnt_next = cnt_reg; swd_next = swd_reg; off_next = off_reg;
        nlen_next = nlen_reg; mle_next = mle_reg; mlc_next = mlc_reg;
        mnd_next = mnd_reg; wacc_next = wacc_reg; fid_next = fid_reg;
        tag_next = tag_reg; fsb_next = fsb_reg;
        req = '0;
        req.burst = t4t_pkg::BR_NONE;
        pos = cnt_reg - 16'd2;
        p = pos - 16'(t4t_pkg::HeaderBytes);
        rb = swd_reg[15:8];
        sw = '0; n = '0; off_sum = '0; mle_sub = '0; new_off = '0;
        rem = '0; le_w = '0; data_pos = '0;
        if (in_vld) begin
            unique case (in_op)
                t4t_pkg::OP_START_READ, t4t_pkg::OP_START_PRESENCE: begin
                    if (phase_reg == t4t_pkg::PH_IDLE) begin
                        cnt_next = '0; swd_next = '0; off_next = '0; nlen_next = '0;
                        mle_next = '0; mlc_next = '0; mnd_next = '0; wacc_next = '0;
                        fid_next = '0; tag_next = '0; fsb_next = '0;
                        req.burst = t4t_pkg::BR_SEL_V2;
                        phase_next = (in_op == t4t_pkg::OP_START_READ) ?
                            t4t_pkg::PH_SEL_V2 : t4t_pkg::PH_PRESENCE;
                    end
                end
                t4t_pkg::OP_XFER_FAIL: begin
                    if (phase_reg != t4t_pkg::PH_IDLE) begin
                        req.burst = t4t_pkg::BR_DONE;
                        req.status = t4t_pkg::ST_LINK_ERR;
                        phase_next = t4t_pkg::PH_IDLE;
                        cnt_next = '0; swd_next = '0; fsb_next = '0;
                    end
                end
                default: begin
                    if (phase_reg != t4t_pkg::PH_IDLE) begin
                        // byte leaving the status-word delay
                        if (cnt_reg >= 16'd2) begin
                            if (pos == 16'd0) fsb_next = rb;
                            if (pos >= 16'(t4t_pkg::HeaderBytes)) begin
                                unique case (phase_reg)
                                    t4t_pkg::PH_READ_CC: begin
                                        unique case (p)
                                            16'd3:  mle_next[15:8] = rb;
                                            16'd4:  mle_next[7:0]  = rb;
                                            16'd5:  mlc_next[15:8] = rb;
                                            16'd6:  mlc_next[7:0]  = rb;
                                            16'd7:  tag_next = rb;
                                            16'd9:  fid_next[15:8] = rb;
                                            16'd10: fid_next[7:0]  = rb;
                                            16'd11: mnd_next[15:8] = rb;
                                            16'd12: mnd_next[7:0]  = rb;
                                            16'd14: wacc_next = rb;
                                            default: ;
                                        endcase
                                    end
                                    t4t_pkg::PH_READ_NLEN: begin
                                        if (p == 16'd0) nlen_next[15:8] = rb;
                                        else if (p == 16'd1) nlen_next[7:0] = rb;
                                    end
                                    t4t_pkg::PH_READ_DATA: begin
                                        data_pos = {1'b0, off_reg} + {1'b0, p};
                                        if (data_pos < {1'b0, nlen_reg}) begin
                                            req.data_vld = 1'b1;
                                            req.data_byte = rb;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        swd_next = {swd_reg[7:0], in_byte};
                        if (cnt_reg != 16'hFFFF) cnt_next = cnt_reg + 16'd1;
                        // end of response
                        if (in_last) begin
                            sw = swd_next;
                            if (cnt_next >= 16'(t4t_pkg::HeaderBytes + 2))
                                n = cnt_next - 16'(t4t_pkg::HeaderBytes + 2);
                            req.status = t4t_pkg::ST_BAD_SW;
                            unique case (phase_reg)
                                t4t_pkg::PH_SEL_V2, t4t_pkg::PH_SEL_V1: begin
                                    if (phase_reg == t4t_pkg::PH_SEL_V2 &&
                                        sw == t4t_pkg::SW_NOT_FND) begin
                                        req.burst = t4t_pkg::BR_SEL_V1;
                                        phase_next = t4t_pkg::PH_SEL_V1;
                                    end else if (sw != t4t_pkg::SW_OK || fsb_next != 8'd0) begin
                                        req.burst = t4t_pkg::BR_DONE;
                                    end else begin
                                        req.burst = t4t_pkg::BR_SEL_FI;
                                        req.fid = 16'hE103;
                                        phase_next = t4t_pkg::PH_SEL_CC;
                                    end
                                end
                                t4t_pkg::PH_SEL_CC, t4t_pkg::PH_SEL_NDEF: begin
                                    if (sw != t4t_pkg::SW_OK) begin
                                        req.burst = t4t_pkg::BR_DONE;
                                    end else begin
                                        req.burst = t4t_pkg::BR_READ;
                                        req.le = 8'h0F;
                                        phase_next = (phase_reg == t4t_pkg::PH_SEL_CC) ?
                                            t4t_pkg::PH_READ_CC : t4t_pkg::PH_READ_NLEN;
                                    end
                                end
                                t4t_pkg::PH_READ_CC: begin
                                    if (sw != t4t_pkg::SW_OK) begin
                                        req.burst = t4t_pkg::BR_DONE;
                                    end else begin
                                        mle_next = (mle_next > 16'd5) ?
                                            mle_next - 16'd5 : 16'd0;
                                        if (tag_next != t4t_pkg::TLV_NDEF) begin
                                            req.burst = t4t_pkg::BR_DONE;
                                            req.status = t4t_pkg::ST_NO_TLV;
                                        end else begin
                                            req.burst = t4t_pkg::BR_SEL_FI;
                                            req.fid = fid_next;
                                            phase_next = t4t_pkg::PH_SEL_NDEF;
                                        end
                                    end
                                end
                                t4t_pkg::PH_READ_NLEN: begin
                                    if (sw != t4t_pkg::SW_OK) begin
                                        req.burst = t4t_pkg::BR_DONE;
                                    end else begin
                                        off_next = '0;
                                        mle_sub = (mle_reg > 16'd2) ? mle_reg - 16'd2 : 16'd0;
                                        req.burst = t4t_pkg::BR_READ;
                                        req.offset = 16'd2;
                                        req.le = (mle_sub > 16'd255) ? 8'hFF : mle_sub[7:0];
                                        phase_next = t4t_pkg::PH_READ_DATA;
                                    end
                                end
                                t4t_pkg::PH_READ_DATA: begin
                                    off_sum = {1'b0, off_reg} + {1'b0, n};
                                    if (sw != t4t_pkg::SW_OK) begin
                                        req.burst = t4t_pkg::BR_DONE;
                                    end else if (off_sum >= {1'b0, nlen_reg}) begin
                                        req.burst = t4t_pkg::BR_DONE;
                                        req.status = t4t_pkg::ST_OK;
                                    end else begin
                                        new_off = off_sum[15:0];
                                        off_next = new_off;
                                        rem = nlen_reg - new_off;
                                        le_w = (rem < mle_reg) ? rem : mle_reg;
                                        req.burst = t4t_pkg::BR_READ;
                                        req.offset = new_off + 16'd2;
                                        req.le = (le_w > 16'd255) ? 8'hFF : le_w[7:0];
                                    end
                                end
                                t4t_pkg::PH_PRESENCE: begin
                                    req.burst = t4t_pkg::BR_DONE;
                                    req.status = t4t_pkg::ST_OK;
                                end
                                default: phase_next = t4t_pkg::PH_IDLE;
                            endcase
                            if (req.burst == t4t_pkg::BR_DONE) phase_next = t4t_pkg::PH_IDLE;
                            cnt_next = '0; swd_next = '0; fsb_next = '0;
                        end
                    end
                end
            endcase
        end
        // completion values as they stand after this item
        req.ndef_length = nlen_next;
        req.read_only = (wacc_next == 8'hFF);
        req.ndef_file_max = mnd_next;
        req.max_command_data = mlc_next;
    end

endmodule

>>> hdl/t4t_emit.sv
module t4t_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  t4t_pkg::burst_req_t  req_in,
    input  logic                 load,
    output logic                 busy,
    output logic                 res_vld,
    output t4t_pkg::result_t     res,
    input  logic                 res_rdy
);

    t4t_pkg::burst_req_t req_reg;
    logic [t4t_pkg::ResCntW-1:0] idx_reg, idx_next;
    logic [t4t_pkg::ResCntW-1:0] cnt_reg, cnt_next;

    logic [t4t_pkg::ResCntW-1:0] load_cnt;
    logic [t4t_pkg::ResCntW-1:0] burst_len;

    // number of results carried by one request
    always_comb begin
        unique case (req_in.burst)
            t4t_pkg::BR_SEL_V2, t4t_pkg::BR_SEL_V1: burst_len = 4'd12;
            t4t_pkg::BR_SEL_FI:                     burst_len = 4'd7;
            t4t_pkg::BR_READ, t4t_pkg::BR_DONE:     burst_len = 4'd5;
            default:                                burst_len = 4'd0;
        endcase
        if (req_in.burst == t4t_pkg::BR_DONE) burst_len = 4'd1;
        load_cnt = burst_len + (req_in.data_vld ? 4'd1 : 4'd0);
    end

    assign busy = (cnt_reg != '0) && !(res_rdy && cnt_reg == 4'd1);

    always_comb begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (res_vld && res_rdy) begin
            idx_next = idx_reg + 4'd1;
            cnt_next = cnt_reg - 4'd1;
        end
        if (load) begin
            idx_next = req_in.data_vld ? 4'd0 : 4'd1;
            cnt_next = load_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    // request held while its results drain
    always_ff @(posedge aclk) begin
        if (load) req_reg <= req_in;
    end

    assign res_vld = (cnt_reg != '0);

    // result byte selection; index 0 is the ndef data byte
    logic [3:0] b;
    logic [7:0] app_last;
    always_comb begin
        res = '0;
        b = idx_reg - 4'd1;
        app_last = (req_reg.burst == t4t_pkg::BR_SEL_V2) ? 8'h01 : 8'h00;
        if (idx_reg == 4'd0) begin
            res.kind = t4t_pkg::KIND_DATA;
            res.value = req_reg.data_byte;
        end else if (req_reg.burst == t4t_pkg::BR_DONE) begin
            res.kind = t4t_pkg::KIND_DONE;
            res.item_last = 1'b1;
            res.status = req_reg.status;
            res.ndef_length = req_reg.ndef_length;
            res.read_only = req_reg.read_only;
            res.ndef_file_max = req_reg.ndef_file_max;
            res.max_command_data = req_reg.max_command_data;
        end else if (req_reg.burst == t4t_pkg::BR_READ) begin
            res.kind = t4t_pkg::KIND_CMD;
            unique case (b)
                4'd0: res.value = 8'h00;
                4'd1: res.value = t4t_pkg::INS_READ;
                4'd2: res.value = req_reg.offset[15:8];
                4'd3: res.value = req_reg.offset[7:0];
                default: begin
                    res.value = req_reg.le;
                    res.item_last = 1'b1;
                end
            endcase
        end else if (req_reg.burst == t4t_pkg::BR_SEL_FI) begin
            res.kind = t4t_pkg::KIND_CMD;
            unique case (b)
                4'd0: res.value = 8'h00;
                4'd1: res.value = t4t_pkg::INS_SELECT;
                4'd2: res.value = 8'h00;
                4'd3: res.value = 8'h00;
                4'd4: res.value = 8'h02;
                4'd5: res.value = req_reg.fid[15:8];
                default: begin
                    res.value = req_reg.fid[7:0];
                    res.item_last = 1'b1;
                end
            endcase
        end else begin
            res.kind = t4t_pkg::KIND_CMD;
            unique case (b)
                4'd0:  res.value = 8'h00;
                4'd1:  res.value = t4t_pkg::INS_SELECT;
                4'd2:  res.value = 8'h04;
                4'd3:  res.value = 8'h00;
                4'd4:  res.value = 8'h07;
                4'd5:  res.value = 8'hD2;
                4'd6:  res.value = 8'h76;
                4'd7:  res.value = 8'h00;
                4'd8:  res.value = 8'h00;
                4'd9:  res.value = 8'h85;
                4'd10: res.value = 8'h01;
                default: begin
                    res.value = app_last;
                    res.item_last = 1'b1;
                end
            endcase
        end
    end

endmodule

>>> hdl/type4_tag_ndef_read_sequencer.sv
// Type 4 tag NDEF read sequencer (reader side).
// Input stream s_*: tdata = resp_byte, tuser = opcode, tlast = resp_last.
// Opcodes: start read, start presence check, response byte, transfer failed.
// Output stream m_*: tuser = kind, tlast = item_last, tdata carries from bit 0
// up value, status, ndef_length, read_only, ndef file size limit and MLc.
// One request yields up to 12 results: command APDU bytes, one NDEF byte
// followed by a read command or a completion, one NDEF byte alone, or a completion alone.
// Latency: an accepted request is decoded in the same cycle by the sequencer
// core and its first result is presented on the next cycle from the emitter.
// Throughput: one result per cycle when the receiver does not stall; s_tready
// drops while a burst of command bytes drains, so the next request waits until
// the burst is out. Response streaming runs at one byte per cycle when the
// receiver does not stall.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties
// the emitter. When the receiver holds m_tready low the current result holds
// and s_tready stays low until the burst can finish.
`include "type4_tag_ndef_read_sequencer_defines.svh"
module type4_tag_ndef_read_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // resp_byte[7:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic        s_tlast,   // resp_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value[7:0], status, ndef_length, read_only,
                                   // ndef_file_max, max_command_data, zero fill
    output logic        m_tlast,   // item_last
    output logic [1:0]  m_tuser    // kind
);

    t4t_pkg::burst_req_t req;
    t4t_pkg::result_t    res;
    logic emit_busy;
    logic accept;

    assign s_tready = !emit_busy;
    assign accept = s_tvalid && s_tready;

    // sequencer core
    t4t_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (accept),
        .in_op   (s_tuser),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .req     (req)
    );

    // result emitter
    t4t_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_in  (req),
        .load    (accept),
        .busy    (emit_busy),
        .res_vld (m_tvalid),
        .res     (res),
        .res_rdy (m_tready)
    );

    // output packing
    assign m_tuser = res.kind;
    assign m_tlast = res.item_last;
    assign m_tdata = {5'd0, res.max_command_data, res.ndef_file_max, res.read_only,
                      res.ndef_length, res.status, res.value};

    `T4T_ASSERT_IMP(a_no_accept_busy, emit_busy, !s_tready, "accept while emitter busy")
    `T4T_ASSERT_IMP(a_done_last, m_tvalid && m_tuser == t4t_pkg::KIND_DONE, m_tlast,
        "completion without last")
    `T4T_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")

endmodule

>>> test/testbench.sv
module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    type4_tag_ndef_read_sequencer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    // expected result of one emitted item
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        last;
        logic [1:0]  status;
        logic [15:0] nlen;
        logic        ro;
        logic [15:0] max_ndef;
        logic [15:0] mlc;
    } tag_result_t;

    tag_result_t apdu_q[$];

    // sequencer shadow state
    t4t_pkg::phase_t ph;
    logic [15:0] rcount, swd, roff, nlen, mle, mlc, mndef, fid;
    logic [7:0]  wacc, tlv, hdr0;

    int  failures = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  hold_cycles = 0;
    bit  calm = 0;

    localparam int CycleLimit = 400000;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic push_res(input logic [1:0] k, input logic [7:0] v, input logic l);
        tag_result_t r;
        r.kind = k; r.value = v; r.last = l;
        r.status = 0; r.nlen = 0; r.ro = 0; r.max_ndef = 0; r.mlc = 0;
        apdu_q.push_back(r);
    endtask

    task automatic push_done(input logic [1:0] st);
        tag_result_t r;
        r.kind = t4t_pkg::KIND_DONE; r.value = 0; r.last = 1; r.status = st;
        r.nlen = nlen; r.ro = (wacc == 8'hFF); r.max_ndef = mndef; r.mlc = mlc;
        apdu_q.push_back(r);
        ph = t4t_pkg::PH_IDLE;
    endtask

    task automatic push_select(input logic [7:0] p1, input logic [7:0] d[$]);
        push_res(t4t_pkg::KIND_CMD, 8'h00, 0);
        push_res(t4t_pkg::KIND_CMD, t4t_pkg::INS_SELECT, 0);
        push_res(t4t_pkg::KIND_CMD, p1, 0);
        push_res(t4t_pkg::KIND_CMD, 8'h00, 0);
        push_res(t4t_pkg::KIND_CMD, 8'(d.size()), 0);
        foreach (d[i]) push_res(t4t_pkg::KIND_CMD, d[i], i == d.size() - 1);
    endtask

    task automatic push_read(input logic [15:0] off, input int unsigned le);
        push_res(t4t_pkg::KIND_CMD, 8'h00, 0);
        push_res(t4t_pkg::KIND_CMD, t4t_pkg::INS_READ, 0);
        push_res(t4t_pkg::KIND_CMD, off[15:8], 0);
        push_res(t4t_pkg::KIND_CMD, off[7:0], 0);
        push_res(t4t_pkg::KIND_CMD, (le > 255) ? 8'hFF : le[7:0], 1);
    endtask

    // byte leaving the status-word delay
    task automatic release_byte(input logic [7:0] b, input int unsigned pos);
        int unsigned p;
        if (pos == 0) hdr0 = b;
        if (pos >= t4t_pkg::HeaderBytes) begin
            p = pos - t4t_pkg::HeaderBytes;
            if (ph == t4t_pkg::PH_READ_CC) begin
                case (p)
                    3:  mle[15:8] = b;
                    4:  mle[7:0] = b;
                    5:  mlc[15:8] = b;
                    6:  mlc[7:0] = b;
                    7:  tlv = b;
                    9:  fid[15:8] = b;
                    10: fid[7:0] = b;
                    11: mndef[15:8] = b;
                    12: mndef[7:0] = b;
                    14: wacc = b;
                    default: ;
                endcase
            end else if (ph == t4t_pkg::PH_READ_NLEN) begin
                if (p == 0) nlen[15:8] = b;
                else if (p == 1) nlen[7:0] = b;
            end else if (ph == t4t_pkg::PH_READ_DATA) begin
                if (roff + p < nlen) push_res(t4t_pkg::KIND_DATA, b, 0);
            end
        end
    endtask

    // decision at the end of each tag response
    task automatic close_response();
        int unsigned n, le, rem;
        logic [7:0] aid[$];
        n = (rcount >= t4t_pkg::HeaderBytes + 2) ? rcount - t4t_pkg::HeaderBytes - 2 : 0;
        case (ph)
            t4t_pkg::PH_SEL_V2, t4t_pkg::PH_SEL_V1: begin
                if (ph == t4t_pkg::PH_SEL_V2 && swd == t4t_pkg::SW_NOT_FND) begin
                    aid = '{8'hD2, 8'h76, 8'h00, 8'h00, 8'h85, 8'h01, 8'h00};
                    push_select(8'h04, aid);
                    ph = t4t_pkg::PH_SEL_V1;
                end else if (swd != t4t_pkg::SW_OK || hdr0 != 0) begin
                    push_done(t4t_pkg::ST_BAD_SW);
                end else begin
                    aid = '{8'hE1, 8'h03};
                    push_select(8'h00, aid);
                    ph = t4t_pkg::PH_SEL_CC;
                end
            end
            t4t_pkg::PH_SEL_CC, t4t_pkg::PH_SEL_NDEF: begin
                if (swd != t4t_pkg::SW_OK) push_done(t4t_pkg::ST_BAD_SW);
                else begin
                    push_read(0, 15);
                    ph = (ph == t4t_pkg::PH_SEL_CC) ? t4t_pkg::PH_READ_CC :
                        t4t_pkg::PH_READ_NLEN;
                end
            end
            t4t_pkg::PH_READ_CC: begin
                if (swd != t4t_pkg::SW_OK) push_done(t4t_pkg::ST_BAD_SW);
                else begin
                    mle = (mle > 5) ? mle - 5 : 0;
                    if (tlv != t4t_pkg::TLV_NDEF) push_done(t4t_pkg::ST_NO_TLV);
                    else begin
                        aid = '{fid[15:8], fid[7:0]};
                        push_select(8'h00, aid);
                        ph = t4t_pkg::PH_SEL_NDEF;
                    end
                end
            end
            t4t_pkg::PH_READ_NLEN: begin
                if (swd != t4t_pkg::SW_OK) push_done(t4t_pkg::ST_BAD_SW);
                else begin
                    roff = 0;
                    push_read(2, (mle > 2) ? mle - 2 : 0);
                    ph = t4t_pkg::PH_READ_DATA;
                end
            end
            t4t_pkg::PH_READ_DATA: begin
                if (swd != t4t_pkg::SW_OK) push_done(t4t_pkg::ST_BAD_SW);
                else if (roff + n >= nlen) push_done(t4t_pkg::ST_OK);
                else begin
                    roff = roff + n;
                    rem = nlen - roff;
                    le = (rem < mle) ? rem : mle;
                    push_read(roff + 16'd2, le);
                end
            end
            t4t_pkg::PH_PRESENCE: push_done(t4t_pkg::ST_OK);
            default: ph = t4t_pkg::PH_IDLE;
        endcase
        rcount = 0; swd = 0; hdr0 = 0;
    endtask

    task automatic predict_request(input logic [1:0] op, input logic [7:0] b, input logic l);
        logic [7:0] aid[$];
        if (op == t4t_pkg::OP_START_READ || op == t4t_pkg::OP_START_PRESENCE) begin
            if (ph == t4t_pkg::PH_IDLE) begin
                rcount = 0; swd = 0; hdr0 = 0; roff = 0; nlen = 0; mle = 0; mlc = 0;
                mndef = 0; wacc = 0; fid = 0; tlv = 0;
                aid = '{8'hD2, 8'h76, 8'h00, 8'h00, 8'h85, 8'h01, 8'h01};
                push_select(8'h04, aid);
                ph = (op == t4t_pkg::OP_START_READ) ? t4t_pkg::PH_SEL_V2 :
                    t4t_pkg::PH_PRESENCE;
            end
        end else if (op == t4t_pkg::OP_XFER_FAIL) begin
            if (ph != t4t_pkg::PH_IDLE) begin
                push_done(t4t_pkg::ST_LINK_ERR);
                rcount = 0; swd = 0; hdr0 = 0;
            end
        end else if (ph != t4t_pkg::PH_IDLE) begin
            if (rcount >= 2) release_byte(swd[15:8], rcount - 16'd2);
            swd = {swd[7:0], b};
            if (rcount != 16'hFFFF) rcount++;
            if (l) close_response();
        end
    endtask

    // one request on the input stream, then, unless calm, sometimes a random gap
    task automatic send_request(input logic [1:0] op, input logic [7:0] b, input logic l);
        int r;
        s_tvalid = 1;
        s_tdata = b;
        s_tuser = op;
        s_tlast = l;
        do @(posedge aclk); while (!s_tready);
        predict_request(op, b, l);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 0;
        r = $urandom_range(0, 99);
        if (!calm && r < 20) repeat ($urandom_range(1, 3)) @(negedge aclk);
        else if (!calm && r < 23) repeat ($urandom_range(10, 40)) @(negedge aclk);
    endtask

    task automatic send_response(input logic [7:0] d[$]);
        foreach (d[i]) send_request(t4t_pkg::OP_RESP_BYTE, d[i], i == d.size() - 1);
    endtask

    // tag answer to the current command; fault_pct injects broken answers
    task automatic answer_tag(input logic [15:0] cc_mle, input logic [15:0] len,
                              input logic [7:0] tlv_v, input int fault_pct);
        logic [7:0] d[$];
        logic [15:0] sw;
        int k, f;
        sw = t4t_pkg::SW_OK;
        d = '{8'h00};
        case (ph)
            t4t_pkg::PH_SEL_V2: if ($urandom_range(0, 1)) sw = t4t_pkg::SW_NOT_FND;
            t4t_pkg::PH_READ_CC: begin
                d = '{8'h00, 8'h00, 8'h0F, 8'h20, cc_mle[15:8], cc_mle[7:0],
                      8'($urandom), 8'($urandom), tlv_v, 8'h06, 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'h00,
                      $urandom_range(0, 1) ? 8'hFF : 8'h00};
            end
            t4t_pkg::PH_READ_NLEN: begin
                d.push_back(len[15:8]); d.push_back(len[7:0]);
                repeat ($urandom_range(0, 13)) d.push_back(8'($urandom));
            end
            t4t_pkg::PH_READ_DATA: begin
                k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                repeat (k) d.push_back(8'($urandom));
            end
            default: ;
        endcase
        f = $urandom_range(0, 99);
        if (f < fault_pct) begin
            case ($urandom_range(0, 4))
                0: sw = 16'($urandom);
                1: d[0] = 8'($urandom_range(1, 255));
                2: begin
                    send_request(t4t_pkg::OP_XFER_FAIL, 8'($urandom), 1'($urandom));
                    return;
                end
                3: begin
                    send_request(t4t_pkg::OP_RESP_BYTE, 8'($urandom), 1);
                    return;
                end
                default: send_request(t4t_pkg::OP_START_READ, 8'($urandom), 1'($urandom));
            endcase
        end
        d.push_back(sw[15:8]); d.push_back(sw[7:0]);
        send_response(d);
    endtask

    task automatic read_run(input logic [15:0] cc_mle, input logic [15:0] len,
                            input logic [7:0] tlv_v, input int fault_pct);
        int guard;
        guard = 0;
        send_request(t4t_pkg::OP_START_READ, 8'($urandom), 1'($urandom));
        while (ph != t4t_pkg::PH_IDLE && guard < 200) begin
            answer_tag(cc_mle, len, tlv_v, fault_pct);
            guard++;
        end
        if (ph != t4t_pkg::PH_IDLE) send_request(t4t_pkg::OP_XFER_FAIL, 8'h00, 0);
    endtask

    // results leave in order and match the shadow model
    always @(posedge aclk) begin
        tag_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (apdu_q.size() == 0) begin
                $display("%0t: unexpected result tuser=%0h tdata=%h", $time, m_tuser, m_tdata);
                failures++;
            end else begin
                e = apdu_q.pop_front();
                if (m_tuser !== e.kind) begin
                    $display("%0t: kind exp %0h got %0h", $time, e.kind, m_tuser);
                    failures++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last exp %0b got %0b", $time, e.last, m_tlast);
                    failures++;
                end
                if (m_tdata[7:0] !== e.value) begin
                    $display("%0t: value exp %h got %h", $time, e.value, m_tdata[7:0]);
                    failures++;
                end
                if (m_tdata[9:8] !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, m_tdata[9:8]);
                    failures++;
                end
                if (m_tdata[25:10] !== e.nlen) begin
                    $display("%0t: ndef_length exp %h got %h", $time, e.nlen, m_tdata[25:10]);
                    failures++;
                end
                if (m_tdata[26] !== e.ro) begin
                    $display("%0t: read_only exp %0b got %0b", $time, e.ro, m_tdata[26]);
                    failures++;
                end
                if (m_tdata[42:27] !== e.max_ndef) begin
                    $display("%0t: ndef_file_max exp %h got %h", $time, e.max_ndef,
                             m_tdata[42:27]);
                    failures++;
                end
                if (m_tdata[58:43] !== e.mlc) begin
                    $display("%0t: max_command_data exp %h got %h", $time, e.mlc,
                             m_tdata[58:43]);
                    failures++;
                end
            end
        end
    end

    // receiver readiness with random stalls and forced hold-off
    initial begin
        int gap;
        int r;
        gap = 0;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 0;
                hold_cycles--;
            end else if (gap > 0) begin
                m_tready = 0;
                gap--;
            end else begin
                m_tready = 1;
                r = $urandom_range(0, 99);
                if (!calm && r < 15) gap = $urandom_range(1, 3);
                else if (!calm && r < 17) gap = $urandom_range(10, 40);
            end
        end
    end

    task automatic test_idle_traffic();
        send_request(t4t_pkg::OP_RESP_BYTE, 8'hFF, 1);
        send_request(t4t_pkg::OP_XFER_FAIL, 8'h00, 0);
    endtask

    task automatic test_presence();
        send_request(t4t_pkg::OP_START_PRESENCE, 8'h00, 0);
        send_request(t4t_pkg::OP_START_READ, 8'hAA, 1);
        send_request(t4t_pkg::OP_RESP_BYTE, 8'h55, 1);
    endtask

    task automatic test_link_fail();
        send_request(t4t_pkg::OP_START_READ, 8'h00, 0);
        send_request(t4t_pkg::OP_RESP_BYTE, 8'h00, 0);
        send_request(t4t_pkg::OP_XFER_FAIL, 8'hFF, 1);
    endtask

    task automatic test_full_reads();
        read_run(16'd12, 16'd9, t4t_pkg::TLV_NDEF, 0);
        read_run(16'hFFFF, 16'd30, t4t_pkg::TLV_NDEF, 0);
        read_run(16'd3, 16'd0, t4t_pkg::TLV_NDEF, 0);
        read_run(16'd20, 16'd5, 8'h05, 0);
    endtask

    task automatic test_stalled_output();
        hold_cycles = 300;
        send_request(t4t_pkg::OP_START_READ, 8'h00, 0);
        send_response('{8'h00, 8'h90, 8'h00});
        send_request(t4t_pkg::OP_XFER_FAIL, 8'h00, 0);
    endtask

    task automatic test_random_runs();
        int r;
        while (items_sent < 240) begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            if (r < 7)
                read_run($urandom_range(0, 1) ? 16'($urandom_range(0, 30)) : 16'($urandom),
                         16'($urandom_range(0, 40)),
                         ($urandom_range(0, 9) == 0) ? 8'($urandom) : t4t_pkg::TLV_NDEF, 6);
            else if (r < 8)
                send_request(2'($urandom), 8'($urandom), 1'($urandom));
            else begin
                send_request(t4t_pkg::OP_START_PRESENCE, 8'($urandom), 1'($urandom));
                repeat ($urandom_range(0, 4))
                    send_request(t4t_pkg::OP_RESP_BYTE, 8'($urandom), 0);
                send_request($urandom_range(0, 3) ? t4t_pkg::OP_RESP_BYTE :
                             t4t_pkg::OP_XFER_FAIL, 8'($urandom), 1);
            end
        end
        calm = 0;
    endtask

    initial begin
        int drain;
        ph = t4t_pkg::PH_IDLE;
        rcount = 0; swd = 0; roff = 0; nlen = 0; mle = 0; mlc = 0; mndef = 0; fid = 0;
        wacc = 0; tlv = 0; hdr0 = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        s_tlast = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        test_idle_traffic();
        test_presence();
        test_link_fail();
        test_full_reads();
        test_stalled_output();
        test_random_runs();

        // let every expected result drain
        drain = 0;
        while (apdu_q.size() != 0 && drain < 20000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (30) @(negedge aclk);
        if (failures == 0 && apdu_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            if (apdu_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, apdu_q.size());
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
